FILE: rtl/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants for the RLE row decoder
// Command format passed from the byte classifier to the pixel emitter, the
// classifier phase encoding and the run group width helper.
// ----------------------------------------------------------------------------
package rle_pkg;

  // Pixels per run group as requested; clamped below to what the port carries
  localparam int GROUP_WIDTH = 8;
  localparam int PIX_FIELDS  = 8;
  localparam int MAX_RESULTS = 16;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int GW_W    = 4;   // holds 1..PIX_FIELDS
  localparam int PCNT_W  = 4;   // pixel_count port width

  localparam int GW_BASE = (GROUP_WIDTH < 1) ? 1 :
                           ((GROUP_WIDTH > PIX_FIELDS) ? PIX_FIELDS : GROUP_WIDTH);

  // Command queue between classifier and emitter
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_LW    = 2;   // level counter, holds 0..Q_DEPTH

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_RUN     = 2'd2
  } phase_t;

  // A count of zero marks the end of the row; a literal is a run of one
  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic [GW_W-1:0]    width;
  } cmd_t;

  // Group width for a run: base width, raised so a run needs at most
  // MAX_RESULTS groups
  function automatic logic [GW_W-1:0] group_width(input logic [COUNT_W-1:0] count);
    logic [COUNT_W:0] sum;
    logic [GW_W-1:0]  need;
    logic [GW_W-1:0]  base;
    sum  = {1'b0, count} + (COUNT_W + 1)'(MAX_RESULTS - 1);
    need = GW_W'(sum >> $clog2(MAX_RESULTS));
    base = GW_W'(GW_BASE);
    return (need > base) ? need : base;
  endfunction

endpackage

FILE: rtl/rle_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_if: stream interfaces of the RLE row decoder
// Coded byte input stream and decoded pixel group output stream, each a
// valid/ready channel with its payload.
// ----------------------------------------------------------------------------
interface rle_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface rle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_a;
  logic [7:0] pixel_b;
  logic [7:0] pixel_c;
  logic [7:0] pixel_d;
  logic [7:0] pixel_e;
  logic [7:0] pixel_f;
  logic [7:0] pixel_g;
  logic [7:0] pixel_h;
  logic [3:0] pixel_count;
  logic       row_end;
  logic       last;

  modport source (output valid, output pixel_a, output pixel_b, output pixel_c,
                  output pixel_d, output pixel_e, output pixel_f, output pixel_g,
                  output pixel_h, output pixel_count, output row_end, output last,
                  input ready);
  modport sink   (input valid, input pixel_a, input pixel_b, input pixel_c,
                  input pixel_d, input pixel_e, input pixel_f, input pixel_g,
                  input pixel_h, input pixel_count, input row_end, input last,
                  output ready);
endinterface

FILE: rtl/rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_front: coded byte classifier
// Tracks header / literal / run phase and turns each byte that produces
// output into one command for the emitter queue.
// ----------------------------------------------------------------------------
module rle_front (
  input  logic              clk,
  input  logic              rst,
  rle_code_if.sink          code,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output rle_pkg::cmd_t     cmd
);

  rle_pkg::phase_t                  phase, phase_next;
  logic [rle_pkg::COUNT_W-1:0]      remaining, remaining_next;
  logic                             emit;
  logic                             accept;
  logic [rle_pkg::COUNT_W-1:0]      hdr_count;

  // Bytes are taken whenever the queue has room
  assign code.ready = cmd_ready;
  assign accept     = code.valid && cmd_ready;
  assign hdr_count  = code.code_byte[rle_pkg::COUNT_W-1:0];
  assign cmd_valid  = code.valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rle_pkg::PH_HEADER;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

  // Phase decode and command build
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    emit           = 1'b0;
    cmd.value      = code.code_byte;
    cmd.count      = '0;
    cmd.width      = rle_pkg::group_width('0);
    unique case (phase)
      rle_pkg::PH_LITERAL: begin
        emit           = 1'b1;
        cmd.count      = rle_pkg::COUNT_W'(1);
        cmd.width      = rle_pkg::group_width(rle_pkg::COUNT_W'(1));
        remaining_next = remaining - rle_pkg::COUNT_W'(1);
        if (remaining_next == '0) begin
          phase_next = rle_pkg::PH_HEADER;
        end
      end
      rle_pkg::PH_RUN: begin
        emit           = 1'b1;
        cmd.count      = remaining;
        cmd.width      = rle_pkg::group_width(remaining);
        phase_next     = rle_pkg::PH_HEADER;
        remaining_next = '0;
      end
      default: begin
        // header byte; the unused code behaves as header too
        if (hdr_count == '0) begin
          emit           = 1'b1;
          phase_next     = rle_pkg::PH_HEADER;
          remaining_next = '0;
        end else begin
          remaining_next = hdr_count;
          phase_next     = code.code_byte[rle_pkg::BYTE_W-1] ? rle_pkg::PH_LITERAL
                                                            : rle_pkg::PH_RUN;
        end
      end
    endcase
  end

endmodule

FILE: rtl/rle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_queue: short command queue
// Two-entry FIFO decoupling the byte classifier from the pixel emitter.
// ----------------------------------------------------------------------------
module rle_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  rle_pkg::cmd_t     push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output rle_pkg::cmd_t     pop_cmd
);

  rle_pkg::cmd_t              entries [rle_pkg::Q_DEPTH];
  logic [rle_pkg::Q_AW-1:0]   wr_ptr;
  logic [rle_pkg::Q_AW-1:0]   rd_ptr;
  logic [rle_pkg::Q_LW-1:0]   level;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (level != rle_pkg::Q_LW'(rle_pkg::Q_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + rle_pkg::Q_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + rle_pkg::Q_AW'(1);
      if (do_push && !do_pop) begin
        level <= level + rle_pkg::Q_LW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - rle_pkg::Q_LW'(1);
      end
    end
  end

endmodule

FILE: rtl/rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_back: pixel group emitter
// Takes one command at a time and issues its pixel groups into an output
// register, one group per cycle while the sink keeps up.
// ----------------------------------------------------------------------------
module rle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  rle_pkg::cmd_t     cmd,
  rle_pix_if.source         pix
);

  // Active command
  logic                          act_valid;
  logic [rle_pkg::BYTE_W-1:0]    act_value;
  logic [rle_pkg::COUNT_W-1:0]   act_left;
  logic [rle_pkg::GW_W-1:0]      act_width;

  // Output register
  logic                          o_valid;
  logic [rle_pkg::BYTE_W-1:0]    o_pix [rle_pkg::PIX_FIELDS];
  logic [rle_pkg::PCNT_W-1:0]    o_count;
  logic                          o_row_end;
  logic                          o_last;

  logic                          slot_free;
  logic                          emit;
  logic                          final_grp;
  logic [rle_pkg::PCNT_W-1:0]    take;
  logic [rle_pkg::COUNT_W-1:0]   width_ext;

  assign width_ext = rle_pkg::COUNT_W'(act_width);
  assign final_grp = (act_left <= width_ext);
  assign take      = final_grp ? rle_pkg::PCNT_W'(act_left) : rle_pkg::PCNT_W'(act_width);
  assign slot_free = !o_valid || pix.ready;
  assign emit      = act_valid && slot_free;
  assign cmd_ready = !act_valid || (emit && final_grp);

  // Command register
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      act_valid <= 1'b1;
      act_value <= cmd.value;
      act_left  <= cmd.count;
      act_width <= cmd.width;
    end else if (emit) begin
      if (final_grp) begin
        act_valid <= 1'b0;
      end else begin
        act_left <= act_left - rle_pkg::COUNT_W'(take);
      end
    end
  end

  // Output register; a zero count only arises for the row end
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (pix.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int i = 0; i < rle_pkg::PIX_FIELDS; i++) begin
        o_pix[i] <= (rle_pkg::PCNT_W'(i) < take) ? act_value : '0;
      end
      o_count   <= take;
      o_row_end <= (act_left == '0);
      o_last    <= final_grp;
    end
  end

  assign pix.valid       = o_valid;
  assign pix.pixel_a     = o_pix[0];
  assign pix.pixel_b     = o_pix[1];
  assign pix.pixel_c     = o_pix[2];
  assign pix.pixel_d     = o_pix[3];
  assign pix.pixel_e     = o_pix[4];
  assign pix.pixel_f     = o_pix[5];
  assign pix.pixel_g     = o_pix[6];
  assign pix.pixel_h     = o_pix[7];
  assign pix.pixel_count = o_count;
  assign pix.row_end     = o_row_end;
  assign pix.last        = o_last;

endmodule

FILE: rtl/rle_row_decoder_top.sv
`timescale 1ns / 1ps
// Path: a byte that yields output passes the queue entry, the command register
// and the output register before its first group shows. Throughput: one coded
// byte per cycle while the command queue has room; a run holds the emitter at one
// group per cycle if the sink keeps up; input stalls once the two-entry queue fills.
// Reset: synchronous, active high; clears phase, queue and output valid.
// ----------------------------------------------------------------------------
// rle_row_decoder_top: run-length coded channel row decoder
// Byte classifier feeding a short command queue and a pixel group emitter.
// ----------------------------------------------------------------------------
module rle_row_decoder_top (
  input  logic       clk,
  input  logic       rst,
  rle_code_if.sink   code,
  rle_pix_if.source  pix
);

  logic              q_in_valid;
  logic              q_in_ready;
  rle_pkg::cmd_t     q_in_cmd;
  logic              q_out_valid;
  logic              q_out_ready;
  rle_pkg::cmd_t     q_out_cmd;

  rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .code      (code),
    .cmd_valid (q_in_valid),
    .cmd_ready (q_in_ready),
    .cmd       (q_in_cmd)
  );

  rle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_cmd   (q_in_cmd),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_cmd    (q_out_cmd)
  );

  rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_out_valid),
    .cmd_ready (q_out_ready),
    .cmd       (q_out_cmd),
    .pix       (pix)
  );

  // Row end request carries no pixels and closes its byte
  a_row_end_shape: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.row_end |-> pix.pixel_count == 4'd0 && pix.last)
    else $error("row end request with pixels or without last");

  // Every non-row-end request carries between one and eight pixels
  a_pix_count_range: assert property (@(posedge clk) disable iff (rst)
    pix.valid && !pix.row_end |-> pix.pixel_count != 4'd0 && pix.pixel_count <= 4'd8)
    else $error("pixel group size out of range");

  // A command is only queued for an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_in_valid && q_in_ready |-> code.valid && code.ready)
    else $error("command queued without an accepted byte");

  // Nothing leaves straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !pix.valid)
    else $error("output valid right after reset");

endmodule
